// ----- hw/rtl/fvsg_pkg.sv -----
// ----------------------------------------------------------------------------
// Formant voice sample generator package
// Shared types and constants for the formant sample generator.
// ----------------------------------------------------------------------------
package fvsg_pkg;

    localparam int SAMPLE_RATE_DEF = 22050;
    localparam int PHASE_BITS_DEF  = 32;

    localparam logic [7:0]  PITCH_RESET = 8'd64;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam logic [12:0] NOISE_SCALE = 13'd4915;

    // odd sine polynomial coefficients, Q1.15 arithmetic
    localparam logic [16:0] SIN_A = 17'd51472;
    localparam logic [16:0] SIN_B = 17'd21024;
    localparam logic [16:0] SIN_C = 17'd2320;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for any 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int DIV_BITS = 64;
    localparam int DVS_BITS = 40;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INC_LOAD,
        ST_INC_R,
        ST_INC_M,
        ST_INC_DONE,
        ST_SIN_X2,
        ST_SIN_T1,
        ST_SIN_T2,
        ST_SIN_S,
        ST_SIN_AMP,
        ST_PITCH,
        ST_NOISE,
        ST_ENV_A,
        ST_ENV_N,
        ST_PROD,
        ST_OUT_LOAD,
        ST_OUT_DIV,
        ST_OUT_SAT
    } t_state;

endpackage

// ----- hw/rtl/formant_voice_sample_generator.sv -----
// ----------------------------------------------------------------------------
// Formant voice sample generator
// Additive three-formant sine synthesis with noise, envelope and gain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transfer per output sample. tuser carries start_req,
//   tdata the formant frequencies/amplitudes, voiced, loudness and length.
//   Master channel: tdata is the signed Q3.12 sample, tlast marks the sample
//   whose index equals phoneme_length - 1.
//   voice_pitch is written through i_cfg_we / i_cfg_wdata; the user must
//   do so only while idle, as the block itself does not enforce it. One
//   shared 36x30 multiplier and one radix-2 restoring divider (one
//   quotient bit per cycle, 64 bits) do all arithmetic under a sequencer.
//   Each formant computes its phase increment in INC_LOAD, INC_R, INC_M
//   and INC_DONE (reciprocal multiplication by the sample rate), plus 5
//   multiplier steps when its frequency is nonzero. Pitch, noise (only
//   when unvoiced), envelope and product follow, then the rounding
//   division (load, 64 steps, sat). s_axis_tready is high only when idle,
//   so a new item is not taken until the last one is through.
//   The result sits in an output register; a stalled receiver holds the
//   sequencer in its last step until the output register frees up.
//   Reset: pitch 64, sample index and phases zero, noise LFSR 0xACE1.
// ----------------------------------------------------------------------------
module formant_voice_sample_generator
    import fvsg_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
    parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // f1_freq, f1_amp, f2_freq, f2_amp, f3_freq, f3_amp, voiced, loudness,
    // phoneme_length
    input  logic [87:0] s_axis_tdata,
    // start_req
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // phase increment: f * 2^PB = f*Q*D + f*R, so
    // inc = f*Q + floor((f*R + D/2) / D), the last term by reciprocal
    localparam longint unsigned PH_ONE = 64'd1 << PHASE_BITS;
    localparam longint unsigned INC_Q  = PH_ONE / 64'(SAMPLE_RATE);
    localparam longint unsigned INC_R  = PH_ONE % 64'(SAMPLE_RATE);
    localparam longint unsigned INC_H  = 64'(SAMPLE_RATE / 2);
    localparam int              INC_L  = $clog2(SAMPLE_RATE);
    localparam int              INC_S  = 13 + 2 * INC_L;
    localparam longint unsigned INC_M  =
        ((64'd1 << INC_S) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);

    t_state r_state, n_state;

    logic [7:0]  r_pitch;
    logic [15:0] r_idx;
    logic [PHASE_BITS-1:0] r_phase [3];
    logic [15:0] r_lfsr;

    logic [12:0] r_freq [3];
    logic [7:0]  r_amp  [3];
    logic        r_voiced;
    logic [7:0]  r_loud;
    logic [15:0] r_len;

    logic [1:0]  r_k;
    logic        r_neg;
    logic [15:0] r_x;
    logic [16:0] r_x2;
    logic [16:0] r_t;
    logic [15:0] r_s;
    logic signed [26:0] r_sum;
    logic signed [35:0] r_w;
    logic [15:0] r_a;
    logic [23:0] r_num;
    logic [20:0] r_den;
    logic signed [61:0] r_prod;
    logic        r_last;
    logic [PHASE_BITS-1:0] r_inc;
    logic [28:0] r_y;

    logic [DIV_BITS-1:0] r_dq;
    logic [DVS_BITS-1:0] r_rem;
    logic [DVS_BITS-1:0] r_dvs;
    logic [5:0]          r_cnt;

    logic        r_ovalid;
    logic [15:0] r_osample;
    logic        r_olast;

    // control outputs
    logic        in_ready;
    logic        out_load;

    // shared multiplier
    logic signed [35:0] mul_a;
    logic        [28:0] mul_b;
    logic signed [61:0] mul_p;

    // datapath helpers
    logic [15:0] p16;
    logic [15:0] fold_r;
    logic [15:0] lfsr_next;
    logic [40:0] div_sh;
    logic [40:0] div_diff;
    logic        div_ge;
    logic [15:0] env_m;
    logic [20:0] env_den;
    logic [61:0] prod_mag;
    logic [15:0] sat_sample;
    logic        in_tail;

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // fold the current phase onto a quarter wave
    assign p16 = r_phase[r_k][PHASE_BITS-1 -: 16];
    always_comb begin
        fold_r = {1'b0, p16[14:0]};
        if (fold_r > 16'd16384) begin
            fold_r = 16'd32768 - fold_r;
        end
    end

    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);

    assign div_sh   = {r_rem, r_dq[DIV_BITS-1]};
    assign div_diff = div_sh - {1'b0, r_dvs};
    assign div_ge   = (div_sh >= {1'b0, r_dvs});

    // envelope factor and denominator
    assign in_tail = (r_idx >= (r_len - r_a));
    always_comb begin
        if (r_idx >= r_len) begin
            env_m   = 16'd0;
            env_den = 21'd255;
        end else if (r_idx < r_a) begin
            env_m   = r_idx;
            env_den = ({5'd0, r_a} << 8) - {5'd0, r_a};
        end else if (in_tail) begin
            env_m   = r_len - r_idx;
            env_den = ({5'd0, r_a} << 8) - {5'd0, r_a};
        end else begin
            env_m   = 16'd1;
            env_den = 21'd255;
        end
    end

    assign prod_mag = r_prod[61] ? 62'(-r_prod) : 62'(r_prod);

    always_comb begin
        if (!r_neg) begin
            sat_sample = (r_dq > 64'd32767) ? 16'h7FFF : r_dq[15:0];
        end else begin
            sat_sample = (r_dq > 64'd32768) ? 16'h8000 : 16'(-r_dq[15:0]);
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_INC_LOAD: begin
                mul_a = 36'(INC_Q);
                mul_b = 29'(r_freq[r_k]);
            end
            ST_INC_R: begin
                mul_a = 36'(INC_R);
                mul_b = 29'(r_freq[r_k]);
            end
            ST_INC_M: begin
                mul_a = 36'(INC_M);
                mul_b = r_y;
            end
            ST_SIN_X2: begin
                mul_a = 36'(r_x);
                mul_b = 29'(r_x);
            end
            ST_SIN_T1: begin
                mul_a = 36'(SIN_C);
                mul_b = 29'(r_x2);
            end
            ST_SIN_T2: begin
                mul_a = 36'(r_x2);
                mul_b = 29'(r_t);
            end
            ST_SIN_S: begin
                mul_a = 36'(r_x);
                mul_b = 29'(r_t);
            end
            ST_SIN_AMP: begin
                mul_a = r_neg ? -36'(r_s) : 36'(r_s);
                mul_b = 29'(r_amp[r_k]);
            end
            ST_PITCH: begin
                mul_a = 36'(r_sum);
                mul_b = 29'({1'b0, r_pitch} + 9'd64);
            end
            ST_NOISE: begin
                mul_a = 36'($signed({2'b00, lfsr_next}) - 18'sd32768);
                mul_b = 29'(NOISE_SCALE);
            end
            ST_ENV_A: begin
                mul_a = 36'(r_len);
                mul_b = 29'(DIV10_MUL);
            end
            ST_ENV_N: begin
                mul_a = 36'(env_m);
                mul_b = 29'(r_loud);
            end
            ST_PROD: begin
                mul_a = r_w;
                mul_b = 29'(r_num);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (s_axis_tvalid) n_state = ST_INC_LOAD;
            ST_INC_LOAD: n_state = ST_INC_R;
            ST_INC_R:    n_state = ST_INC_M;
            ST_INC_M:    n_state = ST_INC_DONE;
            ST_INC_DONE, ST_SIN_AMP: begin
                if (r_state == ST_INC_DONE && r_freq[r_k] != 13'd0) begin
                    n_state = ST_SIN_X2;
                end else if (r_k == 2'd2) begin
                    n_state = ST_PITCH;
                end else begin
                    n_state = ST_INC_LOAD;
                end
            end
            ST_SIN_X2:   n_state = ST_SIN_T1;
            ST_SIN_T1:   n_state = ST_SIN_T2;
            ST_SIN_T2:   n_state = ST_SIN_S;
            ST_SIN_S:    n_state = ST_SIN_AMP;
            ST_PITCH:    n_state = r_voiced ? ST_ENV_A : ST_NOISE;
            ST_NOISE:    n_state = ST_ENV_A;
            ST_ENV_A:    n_state = ST_ENV_N;
            ST_ENV_N:    n_state = ST_PROD;
            ST_PROD:     n_state = ST_OUT_LOAD;
            ST_OUT_LOAD: n_state = ST_OUT_DIV;
            ST_OUT_DIV:  if (r_cnt == 6'd63) n_state = ST_OUT_SAT;
            ST_OUT_SAT:  if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:    in_ready = 1'b1;
            ST_OUT_SAT: out_load = !r_ovalid || m_axis_tready;
            default: begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_osample;
    assign m_axis_tlast  = r_olast;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pitch  <= PITCH_RESET;
            r_idx    <= '0;
            r_lfsr   <= LFSR_SEED;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_cnt    <= '0;
            for (int j = 0; j < 3; j++) begin
                r_phase[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pitch <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (s_axis_tvalid && s_axis_tuser) begin
                        r_idx <= '0;
                        for (int j = 0; j < 3; j++) begin
                            r_phase[j] <= '0;
                        end
                    end
                end
                ST_OUT_LOAD: r_cnt <= '0;
                ST_OUT_DIV:  r_cnt <= r_cnt + 6'd1;
                ST_INC_DONE: begin
                    // advance this formant's phase
                    r_phase[r_k] <= r_phase[r_k] + r_inc;
                    if (r_freq[r_k] == 13'd0) begin
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_SIN_AMP: r_k <= r_k + 2'd1;
                ST_NOISE:   r_lfsr <= lfsr_next;
                ST_OUT_SAT: begin
                    if (out_load && r_idx != 16'hFFFF) begin
                        r_idx <= r_idx + 16'd1;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_osample <= sat_sample;
            r_olast   <= r_last;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_freq[0] <= s_axis_tdata[12:0];
                r_amp[0]  <= s_axis_tdata[20:13];
                r_freq[1] <= s_axis_tdata[33:21];
                r_amp[1]  <= s_axis_tdata[41:34];
                r_freq[2] <= s_axis_tdata[54:42];
                r_amp[2]  <= s_axis_tdata[62:55];
                r_voiced  <= s_axis_tdata[63];
                r_loud    <= s_axis_tdata[71:64];
                r_len     <= s_axis_tdata[87:72];
                r_sum     <= '0;
            end
            ST_INC_LOAD: begin
                r_inc <= mul_p[PHASE_BITS-1:0];
                // hold the pre-advance phase for the sine
                r_neg <= p16[15];
                r_x   <= {fold_r[14:0], 1'b0};
            end
            ST_INC_R: r_y   <= mul_p[28:0] + 29'(INC_H);
            ST_INC_M: r_inc <= r_inc + PHASE_BITS'(mul_p[INC_S +: 14]);
            ST_OUT_DIV: begin
                r_rem <= div_ge ? div_diff[DVS_BITS-1:0] : div_sh[DVS_BITS-1:0];
                r_dq  <= {r_dq[DIV_BITS-2:0], div_ge};
            end
            ST_SIN_X2: r_x2 <= mul_p[31:15];
            ST_SIN_T1: r_t  <= SIN_B - mul_p[31:15];
            ST_SIN_T2: r_t  <= SIN_A - mul_p[31:15];
            ST_SIN_S: begin
                r_s <= (mul_p[47:15] > 33'd32767) ? 16'd32767 : mul_p[30:15];
            end
            ST_SIN_AMP: r_sum <= r_sum + mul_p[26:0];
            ST_PITCH:   r_w   <= mul_p[35:0];
            ST_NOISE:   r_w   <= r_w + mul_p[35:0];
            ST_ENV_A: begin
                r_a    <= mul_p[DIV10_SHIFT+15:DIV10_SHIFT];
                r_last <= (r_len != 16'd0) && (r_idx == r_len - 16'd1);
            end
            ST_ENV_N: begin
                r_num <= mul_p[23:0];
                r_den <= env_den;
            end
            ST_PROD: r_prod <= mul_p;
            ST_OUT_LOAD: begin
                r_dq  <= DIV_BITS'(prod_mag) + (DIV_BITS'(r_den) << 17);
                r_dvs <= DVS_BITS'(r_den) << 18;
                r_rem <= '0;
                r_neg <= r_prod[61];
            end
            default: begin
                r_dvs <= r_dvs;
            end
        endcase
    end

endmodule
